/* rtl/sfrs_pkg.sv */
`default_nettype none
package sfrs_pkg;

  localparam int XW    = 22;
  localparam int MW    = 23;
  localparam int MUW   = 17;
  localparam int NMF   = 9;
  localparam int NRULE = 27;
  localparam int WW    = 49;
  localparam int WZW   = 56;
  localparam int SWW   = 54;
  localparam int SZW   = 60;
  localparam int NUMW  = 68;
  localparam int SCW   = 15;
  localparam int IDXW  = 5;
  localparam int CONFW = 16;

  localparam logic [SWW-1:0]   SUMW_MIN = 54'd28147497671;
  localparam logic [MUW-1:0]   ONE_Q16  = 17'd65536;
  localparam logic [CONFW-1:0] CONF_MIN = 16'd6554;
  localparam logic [CONFW-1:0] CONF_MAX = 16'd64881;
  localparam logic [27:0]      REC_CONF = 28'd171798691;
  localparam logic [19:0]      CONF_DIV = 20'd25;
  localparam logic [19:0]      CONF_RND = 20'd12;

  localparam logic [31:0] REC1   = 32'd4294967295;
  localparam logic [31:0] REC3   = 32'd1431655765;
  localparam logic [31:0] REC5   = 32'd858993459;
  localparam logic [31:0] REC13  = 32'd330382099;
  localparam logic [31:0] REC25  = 32'd171798691;
  localparam logic [31:0] REC45  = 32'd95443717;
  localparam logic [31:0] REC125 = 32'd34359738;

  localparam logic [1:0] LVL_LOW  = 2'd0;
  localparam logic [1:0] LVL_MOD  = 2'd1;
  localparam logic [1:0] LVL_HIGH = 2'd2;

  typedef logic signed [XW-1:0] x_t;
  typedef logic [MUW-1:0] mu_t;
  typedef mu_t [NMF-1:0] mu_set_t;

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_ONE,
    KIND_SLOPE
  } mf_kind_t;

  typedef struct packed {
    x_t          a;
    x_t          b;
    x_t          c;
    x_t          d;
    logic [3:0]  rsh;
    logic [6:0]  ro;
    logic [31:0] rrec;
    logic [3:0]  fsh;
    logic [6:0]  fo;
    logic [31:0] frec;
  } mf_shape_t;

  localparam mf_shape_t MF_SHAPE [NMF] = '{
    '{-22'sd256, 22'sd0, 22'sd512, 22'sd1280,
      4'd8, 7'd1, REC1, 4'd8, 7'd3, REC3},
    '{22'sd512, 22'sd1280, 22'sd1280, 22'sd2560,
      4'd8, 7'd3, REC3, 4'd8, 7'd5, REC5},
    '{22'sd2048, 22'sd3072, 22'sd25600, 22'sd51200,
      4'd6, 7'd1, REC1, 4'd6, 7'd25, REC25},
    '{-22'sd256, 22'sd0, 22'sd2048, 22'sd4608,
      4'd8, 7'd1, REC1, 4'd7, 7'd5, REC5},
    '{22'sd3072, 22'sd5632, 22'sd5632, 22'sd8960,
      4'd7, 7'd5, REC5, 4'd8, 7'd13, REC13},
    '{22'sd7168, 22'sd10240, 22'sd92160, 22'sd184320,
      4'd6, 7'd3, REC3, 4'd5, 7'd45, REC45},
    '{-22'sd128, 22'sd0, 22'sd768, 22'sd2048,
      4'd9, 7'd1, REC1, 4'd8, 7'd5, REC5},
    '{22'sd1536, 22'sd2816, 22'sd2816, 22'sd4096,
      4'd8, 7'd5, REC5, 4'd8, 7'd5, REC5},
    '{22'sd3584, 22'sd5120, 22'sd32000, 22'sd64000,
      4'd7, 7'd3, REC3, 4'd8, 7'd125, REC125}
  };

  localparam logic [6:0] RULE_OUT [NRULE] = '{
    7'd0,  7'd15, 7'd60, 7'd20, 7'd30, 7'd65, 7'd65, 7'd70, 7'd80,
    7'd20, 7'd30, 7'd65, 7'd30, 7'd45, 7'd75, 7'd70, 7'd75, 7'd85,
    7'd70, 7'd75, 7'd85, 7'd75, 7'd80, 7'd90, 7'd85, 7'd95, 7'd100
  };

  typedef struct packed {
    logic [IDXW-1:0] idx;
    logic [1:0]      ci;
    logic [1:0]      cj;
    logic [1:0]      ck;
    logic [1:0]      level;
  } dom_t;

  typedef struct packed {
    logic [SWW-1:0] sum_w;
    logic [SZW-1:0] sum_wz;
    dom_t           dom;
  } agg_t;

  function automatic logic [1:0] level_of(input logic [6:0] z);
    logic [1:0] lvl;
    if (z > 7'd60) begin
      lvl = LVL_HIGH;
    end else if (z > 7'd25) begin
      lvl = LVL_MOD;
    end else begin
      lvl = LVL_LOW;
    end
    return lvl;
  endfunction

endpackage
`default_nettype wire

/* rtl/sfrs_member.sv */
`default_nettype none
module sfrs_member (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [18:0]    speed_var,
  input  logic signed [18:0]    steer_angle,
  input  logic signed [18:0]    accel_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sfrs_pkg::mu_set_t     mu
);
  localparam int NST = 4;
  localparam int MW  = sfrs_pkg::MW;
  localparam int MUW = sfrs_pkg::MUW;

  logic [NST-1:0] v;
  logic [NST-1:0] en;
  sfrs_pkg::x_t   steer_abs;
  sfrs_pkg::x_t   accel_abs;
  sfrs_pkg::x_t   x_next [3];
  sfrs_pkg::x_t   xa [3];

  always_comb begin
    en[NST-1] = !v[NST-1] || out_ready;
    for (int s = NST-2; s >= 0; s--) begin
      en[s] = !v[s] || en[s+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int s = 1; s < NST; s++) begin
        if (en[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  always_comb begin
    steer_abs = steer_angle[18] ? -sfrs_pkg::x_t'(steer_angle) : sfrs_pkg::x_t'(steer_angle);
    accel_abs = accel_value[18] ? -sfrs_pkg::x_t'(accel_value) : sfrs_pkg::x_t'(accel_value);
    x_next[0] = sfrs_pkg::x_t'(speed_var);
    x_next[1] = steer_abs;
    x_next[2] = (accel_abs <<< 2) + accel_abs;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xa <= x_next;
    end
  end

  for (genvar m = 0; m < sfrs_pkg::NMF; m++) begin : g_mf
    localparam sfrs_pkg::mf_shape_t SH = sfrs_pkg::MF_SHAPE[m];
    localparam int XI = m / 3;

    sfrs_pkg::x_t        delta;
    sfrs_pkg::mf_kind_t  kind_next;
    logic                fall_next;
    logic [MW-1:0]       m_next;
    sfrs_pkg::mf_kind_t  kb;
    sfrs_pkg::mf_kind_t  kc;
    logic                fb;
    logic                fc;
    logic [MW-1:0]       mb;
    logic [MW-1:0]       mc;
    logic [MW+31:0]      prod;
    logic [15:0]         qc;
    logic [6:0]          odiv;
    logic [MW-1:0]       qo;
    logic [MW-1:0]       rem;
    logic                inc;
    sfrs_pkg::mu_t       md;

    always_comb begin
      delta     = '0;
      fall_next = 1'b0;
      m_next    = '0;
      if (xa[XI] <= SH.a || xa[XI] >= SH.d) begin
        kind_next = sfrs_pkg::KIND_ZERO;
      end else if (xa[XI] >= SH.b && xa[XI] <= SH.c) begin
        kind_next = sfrs_pkg::KIND_ONE;
      end else if (xa[XI] < SH.b) begin
        kind_next = sfrs_pkg::KIND_SLOPE;
        delta     = xa[XI] - SH.a;
        m_next    = (MW'(delta) << SH.rsh) + MW'(SH.ro >> 1);
      end else begin
        kind_next = sfrs_pkg::KIND_SLOPE;
        fall_next = 1'b1;
        delta     = SH.d - xa[XI];
        m_next    = (MW'(delta) << SH.fsh) + MW'(SH.fo >> 1);
      end
    end

    always_ff @(posedge clk) begin
      if (en[1]) begin
        kb <= kind_next;
        fb <= fall_next;
        mb <= m_next;
      end
    end

    assign prod = mb * (fb ? SH.frec : SH.rrec);

    always_ff @(posedge clk) begin
      if (en[2]) begin
        kc <= kb;
        fc <= fb;
        mc <= mb;
        qc <= prod[47:32];
      end
    end

    assign odiv = fc ? SH.fo : SH.ro;
    assign qo   = MW'(qc) * MW'(odiv);
    assign rem  = mc - qo;
    assign inc  = rem >= MW'(odiv);

    always_ff @(posedge clk) begin
      if (en[3]) begin
        unique case (kc)
          sfrs_pkg::KIND_ZERO:  md <= '0;
          sfrs_pkg::KIND_ONE:   md <= sfrs_pkg::ONE_Q16;
          sfrs_pkg::KIND_SLOPE: md <= MUW'(qc) + MUW'(inc);
          default:              md <= '0;
        endcase
      end
    end

    assign mu[m] = md;
  end

endmodule
`default_nettype wire

/* rtl/sfrs_rules.sv */
`default_nettype none
module sfrs_rules (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sfrs_pkg::mu_set_t mu,
  output logic              out_valid,
  input  logic              out_ready,
  output sfrs_pkg::agg_t    agg
);
  localparam int NST   = 6;
  localparam int MUW   = sfrs_pkg::MUW;
  localparam int WW    = sfrs_pkg::WW;
  localparam int WZW   = sfrs_pkg::WZW;
  localparam int SWW   = sfrs_pkg::SWW;
  localparam int SZW   = sfrs_pkg::SZW;
  localparam int NRULE = sfrs_pkg::NRULE;

  typedef struct packed {
    logic [WW-1:0]  best;
    logic [SWW-1:0] sw;
    logic [SZW-1:0] swz;
    sfrs_pkg::dom_t dom;
  } grp_t;

  function automatic grp_t merge3(input grp_t g0, input grp_t g1, input grp_t g2);
    grp_t g;
    g = g0;
    if (g1.best > g.best) begin
      g.best = g1.best;
      g.dom  = g1.dom;
    end
    if (g2.best > g.best) begin
      g.best = g2.best;
      g.dom  = g2.dom;
    end
    g.sw  = g0.sw + g1.sw + g2.sw;
    g.swz = g0.swz + g1.swz + g2.swz;
    return g;
  endfunction

  logic [NST-1:0]      v;
  logic [NST-1:0]      en;
  logic [2*MUW-1:0]    pe [9];
  sfrs_pkg::mu_t       mae [3];
  logic [WW-1:0]       wf [NRULE];
  logic [WW-1:0]       wg [NRULE];
  logic [WZW-1:0]      wzg [NRULE];
  grp_t                leaf [NRULE];
  grp_t                gh [9];
  grp_t                gi [3];
  grp_t                gj;

  always_comb begin
    en[NST-1] = !v[NST-1] || out_ready;
    for (int s = NST-2; s >= 0; s--) begin
      en[s] = !v[s] || en[s+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int s = 1; s < NST; s++) begin
        if (en[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  for (genvar p = 0; p < 9; p++) begin : g_pair
    localparam int PI = p / 3;
    localparam int PJ = p % 3;
    logic [2*MUW-1:0] pp;
    assign pp = mu[PI] * mu[3+PJ];
    always_ff @(posedge clk) begin
      if (en[0]) begin
        pe[p] <= pp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) begin
        mae[k] <= mu[6+k];
      end
    end
  end

  for (genvar r = 0; r < NRULE; r++) begin : g_rule
    localparam int RI = r / 9;
    localparam int RJ = (r / 3) % 3;
    localparam int RK = r % 3;
    logic [3*MUW-1:0] wp;
    logic [WZW-1:0]   wzp;

    assign wp  = pe[RI*3+RJ] * mae[RK];
    assign wzp = wf[r] * sfrs_pkg::RULE_OUT[r];

    always_ff @(posedge clk) begin
      if (en[1]) begin
        wf[r] <= wp[WW-1:0];
      end
      if (en[2]) begin
        wg[r]  <= wf[r];
        wzg[r] <= wzp;
      end
    end

    always_comb begin
      leaf[r].best      = wg[r];
      leaf[r].sw        = SWW'(wg[r]);
      leaf[r].swz       = SZW'(wzg[r]);
      leaf[r].dom.idx   = sfrs_pkg::IDXW'(r);
      leaf[r].dom.ci    = 2'(RI);
      leaf[r].dom.cj    = 2'(RJ);
      leaf[r].dom.ck    = 2'(RK);
      leaf[r].dom.level = sfrs_pkg::level_of(sfrs_pkg::RULE_OUT[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int g = 0; g < 9; g++) begin
        gh[g] <= merge3(leaf[3*g], leaf[3*g+1], leaf[3*g+2]);
      end
    end
    if (en[4]) begin
      for (int g = 0; g < 3; g++) begin
        gi[g] <= merge3(gh[3*g], gh[3*g+1], gh[3*g+2]);
      end
    end
    if (en[5]) begin
      gj <= merge3(gi[0], gi[1], gi[2]);
    end
  end

  assign agg.sum_w  = gj.sw;
  assign agg.sum_wz = gj.swz;
  assign agg.dom    = gj.dom;

endmodule
`default_nettype wire

/* rtl/sfrs_div.sv */
`default_nettype none
module sfrs_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sfrs_pkg::agg_t                agg,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sfrs_pkg::SCW-1:0]      score,
  output logic [sfrs_pkg::CONFW-1:0]    conf,
  output sfrs_pkg::dom_t                dom
);
  localparam int SCW  = sfrs_pkg::SCW;
  localparam int NUMW = sfrs_pkg::NUMW;
  localparam int SWW  = sfrs_pkg::SWW;
  localparam int NST  = SCW + 3;

  typedef struct packed {
    logic [NUMW-1:0] rem;
    logic [SWW-1:0]  den;
    logic [SCW-1:0]  q;
    logic            small_sum;
    sfrs_pkg::dom_t  dom;
  } div_st_t;

  logic [NST-1:0]     v;
  logic [NST-1:0]     en;
  div_st_t            ds [SCW+1];
  logic [SCW-1:0]     sc;
  logic [19:0]        n_next;
  logic [47:0]        cprod;
  logic [19:0]        c1_n;
  logic [15:0]        c1_qe;
  logic [SCW-1:0]     c1_sc;
  sfrs_pkg::dom_t     c1_dom;
  logic [19:0]        qo;
  logic [19:0]        crem;
  logic [15:0]        qf;
  logic [16:0]        conf_raw;
  logic [sfrs_pkg::CONFW-1:0] conf_next;

  always_comb begin
    en[NST-1] = !v[NST-1] || out_ready;
    for (int s = NST-2; s >= 0; s--) begin
      en[s] = !v[s] || en[s+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int s = 1; s < NST; s++) begin
        if (en[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ds[0].rem       <= {agg.sum_wz, 8'b0} + NUMW'(agg.sum_w >> 1);
      ds[0].den       <= agg.sum_w;
      ds[0].q         <= '0;
      ds[0].small_sum <= agg.sum_w <= sfrs_pkg::SUMW_MIN;
      ds[0].dom       <= agg.dom;
    end
  end

  for (genvar s = 1; s <= SCW; s++) begin : g_bit
    localparam int SH = SCW - s;
    logic [NUMW-1:0] dsh;
    logic            ge;
    assign dsh = NUMW'(ds[s-1].den) << SH;
    assign ge  = ds[s-1].rem >= dsh;
    always_ff @(posedge clk) begin
      if (en[s]) begin
        ds[s].rem       <= ge ? ds[s-1].rem - dsh : ds[s-1].rem;
        ds[s].den       <= ds[s-1].den;
        ds[s].q         <= {ds[s-1].q[SCW-2:0], ge};
        ds[s].small_sum <= ds[s-1].small_sum;
        ds[s].dom       <= ds[s-1].dom;
      end
    end
  end

  assign sc     = ds[SCW].small_sum ? '0 : ds[SCW].q;
  assign n_next = {sc, 5'b0} + sfrs_pkg::CONF_RND;
  assign cprod  = n_next * sfrs_pkg::REC_CONF;

  always_ff @(posedge clk) begin
    if (en[SCW+1]) begin
      c1_sc  <= sc;
      c1_n   <= n_next;
      c1_qe  <= cprod[47:32];
      c1_dom <= ds[SCW].dom;
    end
  end

  assign qo       = {4'b0, c1_qe} * sfrs_pkg::CONF_DIV;
  assign crem     = c1_n - qo;
  assign qf       = c1_qe + 16'(crem >= sfrs_pkg::CONF_DIV);
  assign conf_raw = sfrs_pkg::ONE_Q16 - {1'b0, qf};

  always_comb begin
    if (conf_raw > {1'b0, sfrs_pkg::CONF_MAX}) begin
      conf_next = sfrs_pkg::CONF_MAX;
    end else if (conf_raw < {1'b0, sfrs_pkg::CONF_MIN}) begin
      conf_next = sfrs_pkg::CONF_MIN;
    end else begin
      conf_next = conf_raw[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[SCW+2]) begin
      score <= c1_sc;
      conf  <= conf_next;
      dom   <= c1_dom;
    end
  end

endmodule
`default_nettype wire

/* rtl/sugeno_fuzzy_risk_scorer.sv */
// Three-input, 27-rule zero-order Sugeno risk scorer. Takes one transfer per
// cycle on in_valid/in_ready and returns one result per input, in order, through 28
// register stages: 4 for the membership slopes (reciprocal multiply and
// one-step correction), 6 for the rule weights, weighted sums and the dominant
// rule search, and 18 for the score divider (one quotient bit per stage) and
// the confidence. Throughput stays at one item per cycle while out_ready is
// high; stalls hold every stage and empty stages are filled while stalled.
`default_nettype none
module sugeno_fuzzy_risk_scorer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [18:0] speed_var,
  input  logic signed [18:0] steer_angle,
  input  logic signed [18:0] accel_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [14:0]        risk_score,
  output logic [4:0]         rule_index,
  output logic [1:0]         speed_class,
  output logic [1:0]         steer_class,
  output logic [1:0]         accel_class,
  output logic [1:0]         hazard_level,
  output logic [15:0]        confidence
);
  logic              m_valid;
  logic              m_ready;
  sfrs_pkg::mu_set_t mu;
  logic              r_valid;
  logic              r_ready;
  sfrs_pkg::agg_t    agg;
  sfrs_pkg::dom_t    dom;

  sfrs_member u_member (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .speed_var   (speed_var),
    .steer_angle (steer_angle),
    .accel_value (accel_value),
    .out_valid   (m_valid),
    .out_ready   (m_ready),
    .mu          (mu)
  );

  sfrs_rules u_rules (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m_valid),
    .in_ready  (m_ready),
    .mu        (mu),
    .out_valid (r_valid),
    .out_ready (r_ready),
    .agg       (agg)
  );

  sfrs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r_valid),
    .in_ready  (r_ready),
    .agg       (agg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .score     (risk_score),
    .conf      (confidence),
    .dom       (dom)
  );

  assign rule_index   = dom.idx;
  assign speed_class  = dom.ci;
  assign steer_class  = dom.cj;
  assign accel_class  = dom.ck;
  assign hazard_level = dom.level;

endmodule
`default_nettype wire

/* rtl/sfrs_check.sv */
`default_nettype none
module sfrs_check (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] risk_score,
  input logic [4:0]  rule_index,
  input logic [1:0]  speed_class,
  input logic [1:0]  steer_class,
  input logic [1:0]  accel_class,
  input logic [15:0] confidence
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_conf_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (confidence >= 16'd6554 && confidence <= 16'd64881))
    else $error("confidence out of range");

  a_score_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (risk_score <= 15'd25600 && rule_index <= 5'd26))
    else $error("score or rule index out of range");

  a_rule_classes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rule_index == 5'(speed_class) * 5'd9 + 5'(steer_class) * 5'd3
                   + 5'(accel_class)))
    else $error("rule index does not match classes");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(risk_score) && $stable(confidence))
    else $error("stalled result changed");

endmodule

bind sugeno_fuzzy_risk_scorer sfrs_check u_check (.*);
`default_nettype wire

/* verif/tb_sugeno_fuzzy_risk_scorer.sv */
`default_nettype none
module tb_sugeno_fuzzy_risk_scorer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_IDLE = 12;
  localparam int N_RANDOM = 1300;
  localparam int WATCHDOG = 2000;
  localparam int LATENCY = 28;

  typedef struct packed {
    logic [14:0] score;
    logic [4:0]  idx;
    logic [1:0]  sc;
    logic [1:0]  tc;
    logic [1:0]  ac;
    logic [1:0]  lvl;
    logic [15:0] conf;
  } risk_t;

  class risk_scoreboard;
    risk_t pending[$];
    int errors;
    int checked;

    function automatic longint unsigned ramp(longint signed delta, longint signed span);
      return longint'((delta * 65536 + span / 2) / span);
    endfunction

    function automatic longint unsigned tri_mf(longint signed x, longint signed a,
                                               longint signed b, longint signed c);
      if (x <= a || x >= c) return 0;
      if (x < b) return ramp(x - a, b - a);
      return ramp(c - x, c - b);
    endfunction

    function automatic longint unsigned trap_mf(longint signed x, longint signed a,
                                                longint signed b, longint signed c,
                                                longint signed d);
      if (x <= a || x >= d) return 0;
      if (x >= b && x <= c) return 65536;
      if (x < b) return ramp(x - a, b - a);
      return ramp(d - x, d - c);
    endfunction

    function automatic risk_t score_of(logic signed [18:0] sv_in,
                                       logic signed [18:0] st_in,
                                       logic signed [18:0] ac_in);
      longint signed sv, st, ac;
      longint unsigned ms[3], mt[3], ma[3];
      longint unsigned w, sum_w, sum_wz, best, score, q, rem;
      longint signed conf;
      int dom, r, z;
      risk_t res;
      sv = sv_in;
      st = st_in;
      ac = ac_in;
      if (st < 0) st = -st;
      if (ac < 0) ac = -ac;
      ac = ac * 5;
      ms[0] = trap_mf(sv, -256, 0, 512, 1280);
      ms[1] = tri_mf(sv, 512, 1280, 2560);
      ms[2] = trap_mf(sv, 2048, 3072, 25600, 51200);
      mt[0] = trap_mf(st, -256, 0, 2048, 4608);
      mt[1] = tri_mf(st, 3072, 5632, 8960);
      mt[2] = trap_mf(st, 7168, 10240, 92160, 184320);
      ma[0] = trap_mf(ac, -128, 0, 768, 2048);
      ma[1] = tri_mf(ac, 1536, 2816, 4096);
      ma[2] = trap_mf(ac, 3584, 5120, 32000, 64000);
      sum_w = 0;
      sum_wz = 0;
      best = 0;
      dom = 0;
      score = 0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++) begin
            r = i * 9 + j * 3 + k;
            w = ms[i] * mt[j] * ma[k];
            sum_w += w;
            sum_wz += w * sfrs_pkg::RULE_OUT[r];
            if (r == 0 || w > best) begin
              best = w;
              dom = r;
            end
          end
        end
      end
      if (sum_w > 64'd28147497671) begin
        q = sum_wz / sum_w;
        rem = sum_wz % sum_w;
        score = q * 256 + (rem * 256 + sum_w / 2) / sum_w;
      end
      z = sfrs_pkg::RULE_OUT[dom];
      res.lvl = (z > 60) ? sfrs_pkg::LVL_HIGH : (z > 25) ? sfrs_pkg::LVL_MOD : sfrs_pkg::LVL_LOW;
      conf = 65536 - longint'((score * 32 + 12) / 25);
      if (conf < 6554) conf = 6554;
      if (conf > 64881) conf = 64881;
      res.score = score[14:0];
      res.idx = dom[4:0];
      res.sc = 2'(dom / 9);
      res.tc = 2'((dom / 3) % 3);
      res.ac = 2'(dom % 3);
      res.conf = conf[15:0];
      return res;
    endfunction

    function void note_input(logic signed [18:0] sv, logic signed [18:0] st,
                             logic signed [18:0] ac);
      pending.push_back(score_of(sv, st, ac));
    endfunction

    function void check_result(risk_t got);
      risk_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: score %0d rule %0d", got.score, got.idx);
        return;
      end
      exp_r = pending.pop_front();
      if (got != exp_r) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch #%0d: exp score %0d rule %0d cls %0d/%0d/%0d lvl %0d conf %0d",
                   checked, exp_r.score, exp_r.idx, exp_r.sc, exp_r.tc, exp_r.ac, exp_r.lvl,
                   exp_r.conf);
          $display("             got score %0d rule %0d cls %0d/%0d/%0d lvl %0d conf %0d",
                   got.score, got.idx, got.sc, got.tc, got.ac, got.lvl, got.conf);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [18:0] speed_var = '0;
  logic signed [18:0] steer_angle = '0;
  logic signed [18:0] accel_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [14:0] risk_score;
  logic [4:0] rule_index;
  logic [1:0] speed_class, steer_class, accel_class, hazard_level;
  logic [15:0] confidence;

  risk_scoreboard scores = new();
  int idle_cycles = 0;
  int sent = 0;
  bit stim_done = 0;
  bit hold_off = 0;

  always #2 clk = ~clk;

  sugeno_fuzzy_risk_scorer dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .speed_var(speed_var), .steer_angle(steer_angle), .accel_value(accel_value),
    .out_valid(out_valid), .out_ready(out_ready), .risk_score(risk_score),
    .rule_index(rule_index), .speed_class(speed_class), .steer_class(steer_class),
    .accel_class(accel_class), .hazard_level(hazard_level), .confidence(confidence)
  );

  function automatic logic signed [18:0] near_break();
    int pts[] = '{0, 256, 512, 1280, 2048, 2560, 3072, 4608, 5632, 7168, 8960, 10240,
                  25600, 51200, 92160, 184320, 307, 563, 410, 819, 717, 1024, 6400,
                  12800, 262143};
    int v;
    v = pts[$urandom_range(pts.size() - 1)] + $urandom_range(6) - 3;
    if (v > 262143) v = 262143;
    if ($urandom_range(1)) v = -v;
    return 19'(v);
  endfunction

  function automatic logic signed [18:0] pick_field();
    case ($urandom_range(3))
      0: return 19'($urandom);
      1: return 19'($urandom_range(12800));
      default: return near_break();
    endcase
  endfunction

  task automatic send(logic signed [18:0] sv, logic signed [18:0] st, logic signed [18:0] ac,
                      int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    speed_var <= sv;
    steer_angle <= st;
    accel_value <= ac;
    do @(posedge clk); while (!in_ready);
    scores.note_input(sv, st, ac);
    sent++;
  endtask

  task automatic send_next(logic signed [18:0] sv, logic signed [18:0] st,
                           logic signed [18:0] ac);
    int gap;
    gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(MAX_IDLE);
    if (sent % 200 < 60) gap = 0;
    send(sv, st, ac, gap);
  endtask

  initial begin
    logic signed [18:0] ext[] = '{19'sh3FFFF, 19'sh40000, 19'sd0, -19'sd1, 19'sd1};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (ext[i]) send(ext[i], ext[(i + 1) % 5], ext[(i + 2) % 5], 0);
    send(19'sd1280, 19'sd5632, 19'sd563, 1);
    send(19'sd640, 19'sd3000, 19'sd300, 0);
    send(19'sd3072, -19'sd10240, -19'sd1024, 2);
    send(19'sd51200, 19'sd184320, 19'sd12800, 0);
    send(-19'sd300, -19'sd300, -19'sd300, 0);
    send(19'sd2300, 19'sd8000, 19'sd700, 3);
    send(19'sd900, 19'sd4000, 19'sd2048, 0);
    send(19'sd25600, 19'sd92160, 19'sd6400, 0);
    for (int n = 0; n < N_RANDOM; n++) send_next(pick_field(), pick_field(), pick_field());
    in_valid <= 1'b0;
    stim_done = 1;
  end

  initial begin
    wait (sent >= 300);
    hold_off = 1;
    repeat (80) @(posedge clk);
    hold_off = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        scores.check_result('{risk_score, rule_index, speed_class, steer_class, accel_class,
                              hazard_level, confidence});
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int wait_n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (wait_n > 0) begin
        out_ready <= 1'b0;
        wait_n--;
      end else if (out_ready && out_valid) begin
        wait_n = (sent % 200 < 60) ? 0 : $urandom_range(MAX_IDLE);
        out_ready <= (wait_n == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    wait (stim_done && scores.pending.size() == 0);
    repeat (LATENCY * 2) @(posedge clk);
    $display("covered %0d transfers in, %0d results checked, including extremes,",
             sent, scores.checked);
    $display("membership breakpoints and a long output stall");
    if (scores.errors == 0 && scores.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", scores.errors);
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG);
    $display("watchdog: no transfer for %0d cycles", WATCHDOG);
    $display("FAILED: results differ");
    $finish;
  end
endmodule
`default_nettype wire

/* sugeno_fuzzy_risk_scorer.f */
rtl/sfrs_pkg.sv
rtl/sfrs_member.sv
rtl/sfrs_rules.sv
rtl/sfrs_div.sv
rtl/sugeno_fuzzy_risk_scorer.sv
rtl/sfrs_check.sv
verif/tb_sugeno_fuzzy_risk_scorer.sv
